>>> src/bdfl_pkg.sv
// Shared types, constants and the majority vote function for the button debouncer.
package bdfl_pkg;

   localparam int SampleCount = 5;
   localparam int VoteMajority = 3;

   localparam logic [1:0] EDGE_NONE    = 2'd0;
   localparam logic [1:0] EDGE_PRESS   = 2'd1;
   localparam logic [1:0] EDGE_RELEASE = 2'd2;

   localparam logic [1:0] CSR_DEBOUNCE    = 2'd0;
   localparam logic [1:0] CSR_FLAP_WINDOW = 2'd1;
   localparam logic [1:0] CSR_FLAP_THRESH = 2'd2;
   localparam logic [1:0] CSR_LOCKOUT     = 2'd3;

   localparam logic [15:0] DEBOUNCE_RESET    = 16'd80;
   localparam logic [15:0] FLAP_WINDOW_RESET = 16'd1000;
   localparam logic [7:0]  FLAP_THRESH_RESET = 8'd8;
   localparam logic [31:0] LOCKOUT_RESET     = 32'd3000;

   localparam logic [7:0] FLAP_MAX = 8'hFF;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] flap_window_ms;
      logic [7:0]  flap_threshold;
      logic [31:0] lockout_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0] edge_kind;
      logic       lockout_started;
      logic       stable_level;
      logic       in_lockout;
   } result_type;

   function automatic logic vote_pressed(input logic [SampleCount-1:0] bits);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < SampleCount; i++) begin
         n = n + {2'd0, bits[i]};
      end
      return n >= 3'(VoteMajority);
   endfunction

endpackage

>>> src/bdfl_csr.sv
// Configuration register file for the button debouncer.
module bdfl_csr
   import bdfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_RESET;
         cfg_ff.flap_window_ms <= FLAP_WINDOW_RESET;
         cfg_ff.flap_threshold <= FLAP_THRESH_RESET;
         cfg_ff.lockout_ms     <= LOCKOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    cfg_ff.debounce_ms    <= csr_wdata[15:0];
            CSR_FLAP_WINDOW: cfg_ff.flap_window_ms <= csr_wdata[15:0];
            CSR_FLAP_THRESH: cfg_ff.flap_threshold <= csr_wdata[7:0];
            CSR_LOCKOUT:     cfg_ff.lockout_ms     <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> src/bdfl_core.sv
// Debounce state, flap counting and lockout logic for one transaction per cycle while step_en is high.
module bdfl_core
   import bdfl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [31:0]            now_ms,
   input  logic [SampleCount-1:0] raw_samples,
   input  cfg_type                cfg,
   output result_type             res
);

   logic        last_vote_ff, last_vote_in;
   logic        stable_ff, stable_in;
   logic [31:0] last_change_ff, last_change_in;
   logic [7:0]  flap_count_ff, flap_count_in;
   logic [31:0] window_start_ff, window_start_in;
   logic [31:0] lockout_until_ff, lockout_until_in;

   logic        vote;
   logic        locked;
   logic        win_close;
   logic        start;
   logic        lv_mid;
   logic        sp_mid;
   logic [31:0] lct_mid;
   logic [7:0]  fc_mid;
   logic [31:0] chg_el;
   logic        fast;
   logic [1:0]  edge_kind;

   always_comb begin
      vote      = vote_pressed(raw_samples);
      locked    = now_ms < lockout_until_ff;
      win_close = (now_ms - window_start_ff) >= {16'd0, cfg.flap_window_ms};
      start     = win_close && (flap_count_ff != 8'd0)
                  && (flap_count_ff >= cfg.flap_threshold);
      lv_mid    = start ? vote : last_vote_ff;
      sp_mid    = start ? vote : stable_ff;
      lct_mid   = start ? now_ms : last_change_ff;
      fc_mid    = win_close ? 8'd0 : flap_count_ff;
      chg_el    = now_ms - lct_mid;
      fast      = chg_el < {16'd0, cfg.debounce_ms};

      last_vote_in     = lv_mid;
      stable_in        = sp_mid;
      last_change_in   = lct_mid;
      flap_count_in    = fc_mid;
      window_start_in  = win_close ? now_ms : window_start_ff;
      lockout_until_in = start ? now_ms + cfg.lockout_ms : lockout_until_ff;
      edge_kind        = EDGE_NONE;

      if (vote != lv_mid) begin
         if (fast && fc_mid != FLAP_MAX) begin
            flap_count_in = fc_mid + 8'd1;
         end
         last_vote_in   = vote;
         last_change_in = now_ms;
      end else if (!fast && vote != sp_mid) begin
         stable_in = vote;
         edge_kind = vote ? EDGE_PRESS : EDGE_RELEASE;
      end

      if (locked) begin
         res.edge_kind       = EDGE_NONE;
         res.lockout_started = 1'b0;
         res.stable_level    = stable_ff;
         res.in_lockout      = 1'b1;
      end else begin
         res.edge_kind       = edge_kind;
         res.lockout_started = start;
         res.stable_level    = stable_in;
         res.in_lockout      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_vote_ff     <= 1'b0;
         stable_ff        <= 1'b0;
         last_change_ff   <= 32'd0;
         flap_count_ff    <= 8'd0;
         window_start_ff  <= 32'd0;
         lockout_until_ff <= 32'd0;
      end else if (step_en && !locked) begin
         last_vote_ff     <= last_vote_in;
         stable_ff        <= stable_in;
         last_change_ff   <= last_change_in;
         flap_count_ff    <= flap_count_in;
         window_start_ff  <= window_start_in;
         lockout_until_ff <= lockout_until_in;
      end
   end

   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && locked |=> $stable(stable_ff) && $stable(flap_count_ff))
      else $error("state changed during lockout");

   a_press_level: assert property (@(posedge clock) disable iff (reset)
      step_en && res.edge_kind == EDGE_PRESS |=> stable_ff)
      else $error("press edge without pressed level");

   a_start_no_edge: assert property (@(posedge clock) disable iff (reset)
      res.lockout_started |-> res.edge_kind == EDGE_NONE && !res.in_lockout)
      else $error("lockout start reported an edge");

   a_lock_end: assert property (@(posedge clock) disable iff (reset)
      step_en && res.lockout_started
      |=> lockout_until_ff == $past(now_ms + cfg.lockout_ms))
      else $error("lockout end time wrong");

endmodule

>>> src/button_debounce_flap_lockout.sv
// Top level of the button debouncer with majority vote and flap lockout.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_now_ms, req_raw_samples
//   rsp      out        rsp_valid/rsp_ready    rsp_edge_kind, rsp_lockout_started,
//                                              rsp_stable_level, rsp_in_lockout
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_ready stays high; the req passes the input
// register, then the state update and the result register, before rsp_valid rises.
// The state update of one transaction feeds the next.
// Synchronous reset restores the register defaults and the released state.
// A stalled rsp holds the input register; req_ready follows rsp_ready through it.
module button_debounce_flap_lockout
   import bdfl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_now_ms,
   input  logic [SampleCount-1:0] req_raw_samples,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_edge_kind,
   output logic                   rsp_lockout_started,
   output logic                   rsp_stable_level,
   output logic                   rsp_in_lockout,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);

   cfg_type    cfg;
   result_type res;
   result_type rsp_ff;

   logic                   s1_valid_ff, s1_valid_in;
   logic [31:0]            s1_now_ff;
   logic [SampleCount-1:0] s1_raw_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance;
   logic                   req_fire;

   bdfl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdfl_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .now_ms      (s1_now_ff),
      .raw_samples (s1_raw_ff),
      .cfg         (cfg),
      .res         (res)
   );

   always_comb begin
      advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || advance;
      req_fire     = req_valid && req_ready;
      s1_valid_in  = req_fire || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_now_ff <= req_now_ms;
         s1_raw_ff <= req_raw_samples;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_edge_kind       = rsp_ff.edge_kind;
   assign rsp_lockout_started = rsp_ff.lockout_started;
   assign rsp_stable_level    = rsp_ff.stable_level;
   assign rsp_in_lockout      = rsp_ff.in_lockout;

endmodule
